@@ rtl/core/rvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rvm_pkg;

  localparam int MAX_FRAME_DEF = 65536;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [16:0] FRAME_LEN_RESET = 17'd1024;
  localparam logic [16:0] FRAME_LEN_MAX = 17'd65536;
  localparam logic [23:0] NORM_MIN = 24'd256;
  localparam logic [15:0] POWER_MIN = 16'd41;
  localparam logic [15:0] POWER_ONE = 16'd4096;
  localparam logic [15:0] POWER_HALF = 16'd2048;
  localparam logic [15:0] POWER_TWO = 16'd8192;
  localparam logic [15:0] VOL_FULL = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LENGTH = 3'd0,
    CFG_FRAME_MODE   = 3'd1,
    CFG_GATE_LEVEL   = 3'd2,
    CFG_NORMALIZER   = 3'd3,
    CFG_CURVE_POWER  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_ctl_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [63:0] res;
    rem = '0;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | 68'((v >> (2 * i)) & 64'd3);
      trial = 68'({res, 2'b01});
      if (rem >= trial) begin
        rem = rem - trial;
        res = {res[62:0], 1'b1};
      end else begin
        res = {res[62:0], 1'b0};
      end
    end
    return res;
  endfunction

  // Successive square roots of two in Q2.30, one entry per fraction bit.
  function automatic logic [511:0] root_tab();
    logic [511:0] t;
    logic [63:0] root;
    t = '0;
    root = isqrt_c(64'h2000_0000_0000_0000);
    for (int k = 0; k < 16; k++) begin
      t[k*32 +: 32] = root[31:0];
      root = isqrt_c(root << 30);
    end
    return t;
  endfunction

  localparam logic [511:0] ROOT_TAB = root_tab();

endpackage

`default_nettype wire

@@ rtl/core/rvm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rvm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               end_of_buffer;

  modport source(output valid, sample, end_of_buffer, input ready);
  modport sink(input valid, sample, end_of_buffer, output ready);
endinterface

interface rvm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] volume;
  logic        gated;
  logic [15:0] frame_number;
  logic        truncated;

  modport source(output valid, volume, gated, frame_number, truncated, input ready);
  modport sink(input valid, volume, gated, frame_number, truncated, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rvm_divsqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rvm_divsqrt #(
  parameter int DW = 24
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rvm_pkg::ds_ctl_t ctl,
  input  wire logic [63:0]     opnd,
  input  wire logic [DW-1:0]   dvsr,
  output logic      [63:0]     res,
  output logic                 done
);

  localparam int RW = (DW + 1 > 36) ? DW + 1 : 36;

  logic             busy_r;
  logic             done_r;
  rvm_pkg::ds_op_t  op_r;
  logic [6:0]       cnt_r;
  logic [63:0]      opnd_r;
  logic [DW-1:0]    dvsr_r;
  logic [RW-1:0]    rem_r;
  logic [63:0]      res_r;

  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             ge;

  always_comb begin
    if (op_r == rvm_pkg::DS_DIV) begin
      rem_sh = {rem_r[RW-2:0], opnd_r[63]};
      trial = RW'(dvsr_r);
    end else begin
      rem_sh = {rem_r[RW-3:0], opnd_r[63:62]};
      trial = RW'({res_r[31:0], 2'b01});
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 7'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r <= ctl.op;
      cnt_r <= (ctl.op == rvm_pkg::DS_DIV) ? 7'd63 : 7'd31;
      opnd_r <= opnd;
      dvsr_r <= dvsr;
      rem_r <= '0;
      res_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      opnd_r <= (op_r == rvm_pkg::DS_DIV) ? {opnd_r[62:0], 1'b0} : {opnd_r[61:0], 2'b00};
      rem_r <= ge ? rem_sh - trial : rem_sh;
      res_r <= {res_r[62:0], ge};
    end
  end

  assign res = res_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/core/framed_rms_volume_meter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame RMS volume meter. While a frame is open the block takes one sample per
// cycle. The sample that closes a frame starts the frame-end computation, and the
// input stays not ready until the result sits in the output register. The
// mean-square divide (64 steps), the square root (32 steps) and the divide by the
// normalizer (64 steps) run one after another on one shared shift-subtract unit.
// The result is registered after the root for a gated frame, after the normalizer
// divide for power 1.0 or for a quotient of zero or one that overflows, after a
// squaring on the multiplier for power 2.0, after a second 32-step root for power
// 0.5 and after 16 squaring and 16 multiply steps on the one multiplier otherwise.
// A trailing result that is not taken holds the block after the next frame.
module framed_rms_volume_meter #(
  parameter int MAX_FRAME = rvm_pkg::MAX_FRAME_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rvm_in_if.sink                             in_ch,
  rvm_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rvm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = ($clog2(MAX_FRAME + 2) > 17) ? $clog2(MAX_FRAME + 2) : 17;
  localparam int DW = (CW > 24) ? CW : 24;
  localparam logic [CW-1:0] MAXF = CW'(MAX_FRAME);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DIV1  = 12'b0000_0000_0010,
    ST_SQRT1 = 12'b0000_0000_0100,
    ST_DIV2  = 12'b0000_0000_1000,
    ST_SQRT2 = 12'b0000_0001_0000,
    ST_SQ    = 12'b0000_0010_0000,
    ST_LOGI  = 12'b0000_0100_0000,
    ST_LOG   = 12'b0000_1000_0000,
    ST_EXPO  = 12'b0001_0000_0000,
    ST_EXP   = 12'b0010_0000_0000,
    ST_FIN   = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  rvm_pkg::ds_ctl_t ds_ctl_r, ds_ctl_nxt;

  logic [16:0] frame_length_r;
  logic        frame_mode_r;
  logic [23:0] gate_r;
  logic [23:0] norm_div_r;
  logic [15:0] power_r;

  logic [46:0]   sum_r, sum_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   fcnt_r, fcnt_nxt;
  logic          ov_r, ov_nxt;

  logic [46:0]   snap_sum_r, snap_sum_nxt;
  logic [CW-1:0] snap_n_r, snap_n_nxt;
  logic [15:0]   num_r, num_nxt;
  logic          trunc_r, trunc_nxt;
  logic          emit;

  logic [31:0] rms_r;
  logic [15:0] norm_r;
  logic [3:0]  p_r;
  logic [30:0] y_r;
  logic [15:0] frac_r;
  logic [3:0]  k_r;
  logic [15:0] g_r;
  logic [6:0]  shift_r;
  logic        zero_r;
  logic [31:0] acc_r;
  logic [15:0] vol_r;
  logic        gated_r;

  logic        out_valid_r;
  logic [15:0] out_vol_r;
  logic        out_gated_r;
  logic [15:0] out_num_r;
  logic        out_trunc_r;

  logic        in_acc;
  logic [31:0] sq_full;
  logic [47:0] sum_add;
  logic [46:0] sum_sat;
  logic [CW-1:0] cnt_inc;

  logic [63:0]   ds_opnd;
  logic [DW-1:0] ds_dvsr;
  logic [63:0]   ds_res;
  logic          ds_done;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [3:0]  lead;
  logic [30:0] y0;
  logic [20:0] mag;
  logic [24:0] e_val;
  logic [8:0]  ip;
  logic [6:0]  ip_sat;
  logic [31:0] t_sq;
  logic [31:0] acc_sh;
  logic [47:0] norm_q;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= rvm_pkg::FRAME_LEN_RESET;
      frame_mode_r <= 1'b0;
      gate_r <= '0;
      norm_div_r <= rvm_pkg::NORM_MIN;
      power_r <= rvm_pkg::POWER_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        rvm_pkg::CFG_FRAME_LENGTH: begin
          if (cfg_wdata[16:0] == 17'd0) begin
            frame_length_r <= 17'd1;
          end else if (cfg_wdata[16:0] > rvm_pkg::FRAME_LEN_MAX) begin
            frame_length_r <= rvm_pkg::FRAME_LEN_MAX;
          end else begin
            frame_length_r <= cfg_wdata[16:0];
          end
        end
        rvm_pkg::CFG_FRAME_MODE: frame_mode_r <= cfg_wdata[0];
        rvm_pkg::CFG_GATE_LEVEL: gate_r <= cfg_wdata[23:0];
        rvm_pkg::CFG_NORMALIZER: begin
          norm_div_r <= (cfg_wdata[23:0] < rvm_pkg::NORM_MIN) ? rvm_pkg::NORM_MIN
                                                               : cfg_wdata[23:0];
        end
        rvm_pkg::CFG_CURVE_POWER: begin
          power_r <= (cfg_wdata[15:0] < rvm_pkg::POWER_MIN) ? rvm_pkg::POWER_MIN
                                                             : cfg_wdata[15:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sq_full = 32'(in_ch.sample * in_ch.sample);
    sum_add = {1'b0, sum_r} + {17'd0, sq_full[30:0]};
    sum_sat = sum_add[47] ? {47{1'b1}} : sum_add[46:0];
    cnt_inc = cnt_r + CW'(1);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    fcnt_nxt = fcnt_r;
    ov_nxt = ov_r;
    emit = 1'b0;
    snap_sum_nxt = sum_sat;
    snap_n_nxt = cnt_inc;
    num_nxt = fcnt_r;
    trunc_nxt = 1'b0;
    if (frame_mode_r == 1'b0) begin
      sum_nxt = sum_sat;
      cnt_nxt = cnt_inc;
      if (cnt_inc >= CW'(frame_length_r)) begin
        emit = 1'b1;
        sum_nxt = '0;
        cnt_nxt = '0;
        ov_nxt = 1'b0;
        fcnt_nxt = fcnt_r + 16'd1;
      end
      if (in_ch.end_of_buffer) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        ov_nxt = 1'b0;
        fcnt_nxt = '0;
      end
    end else begin
      if (cnt_r < MAXF) begin
        sum_nxt = sum_sat;
        cnt_nxt = cnt_inc;
      end else begin
        ov_nxt = 1'b1;
      end
      snap_sum_nxt = sum_nxt;
      snap_n_nxt = cnt_nxt;
      num_nxt = '0;
      trunc_nxt = ov_nxt;
      if (in_ch.end_of_buffer) begin
        emit = 1'b1;
        sum_nxt = '0;
        cnt_nxt = '0;
        ov_nxt = 1'b0;
        fcnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      fcnt_r <= '0;
      ov_r <= 1'b0;
    end else if (in_acc) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      fcnt_r <= fcnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      snap_sum_r <= snap_sum_nxt;
      snap_n_r <= (snap_n_nxt == '0) ? CW'(1) : snap_n_nxt;
      num_r <= num_nxt;
      trunc_r <= trunc_nxt;
    end
  end

  always_comb begin
    case (state_r)
      ST_DIV1: begin
        ds_opnd = {1'b0, snap_sum_r, 16'd0};
        ds_dvsr = DW'(snap_n_r);
      end
      ST_DIV2: begin
        ds_opnd = {16'd0, rms_r, 16'd0};
        ds_dvsr = DW'(norm_div_r);
      end
      ST_SQRT2: begin
        ds_opnd = {34'd0, norm_r, 14'd0};
        ds_dvsr = DW'(norm_div_r);
      end
      default: begin
        ds_opnd = ds_res;
        ds_dvsr = DW'(norm_div_r);
      end
    endcase
  end

  rvm_divsqrt #(
    .DW(DW)
  ) u_divsqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ds_ctl_r),
    .opnd (ds_opnd),
    .dvsr (ds_dvsr),
    .res  (ds_res),
    .done (ds_done)
  );

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (norm_r[i]) begin
        lead = 4'(i);
      end
    end
    y0 = 31'(norm_r) << (5'd30 - {1'b0, lead});
    mag = {5'd16 - {1'b0, p_r}, 16'd0} - {5'd0, frac_r};
    case (state_r)
      ST_LOG: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      ST_EXPO: begin
        mul_a = {16'd0, power_r};
        mul_b = {11'd0, mag};
      end
      ST_EXP: begin
        mul_a = acc_r;
        mul_b = rvm_pkg::ROOT_TAB[{k_r, 5'd0} +: 32];
      end
      default: begin
        mul_a = {16'd0, norm_r};
        mul_b = {16'd0, norm_r};
      end
    endcase
    prod = mul_a * mul_b;
    t_sq = prod[61:30];
    e_val = prod[36:12];
    ip = e_val[24:16];
    ip_sat = (ip > 9'd64) ? 7'd64 : ip[6:0];
    acc_sh = acc_r >> shift_r[5:0];
    norm_q = ds_res[47:0];
  end

  always_comb begin
    state_nxt = state_r;
    ds_ctl_nxt = '{start: 1'b0, op: rvm_pkg::DS_DIV};
    case (state_r)
      ST_IDLE: begin
        if (in_acc && emit) begin
          state_nxt = ST_DIV1;
          ds_ctl_nxt = '{start: 1'b1, op: rvm_pkg::DS_DIV};
        end
      end
      ST_DIV1: begin
        if (ds_done) begin
          state_nxt = ST_SQRT1;
          ds_ctl_nxt = '{start: 1'b1, op: rvm_pkg::DS_SQRT};
        end
      end
      ST_SQRT1: begin
        if (ds_done) begin
          if (ds_res[31:0] < {8'd0, gate_r}) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DIV2;
            ds_ctl_nxt = '{start: 1'b1, op: rvm_pkg::DS_DIV};
          end
        end
      end
      ST_DIV2: begin
        if (ds_done) begin
          if (norm_q == 48'd0 || norm_q[47:16] != 32'd0 || power_r == rvm_pkg::POWER_ONE) begin
            state_nxt = ST_OUT;
          end else if (power_r == rvm_pkg::POWER_HALF) begin
            state_nxt = ST_SQRT2;
            ds_ctl_nxt = '{start: 1'b1, op: rvm_pkg::DS_SQRT};
          end else if (power_r == rvm_pkg::POWER_TWO) begin
            state_nxt = ST_SQ;
          end else begin
            state_nxt = ST_LOGI;
          end
        end
      end
      ST_SQRT2: begin
        if (ds_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_SQ: state_nxt = ST_OUT;
      ST_LOGI: state_nxt = ST_LOG;
      ST_LOG: begin
        if (k_r == 4'd15) begin
          state_nxt = ST_EXPO;
        end
      end
      ST_EXPO: state_nxt = ST_EXP;
      ST_EXP: begin
        if (k_r == 4'd15) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ds_ctl_r <= '{start: 1'b0, op: rvm_pkg::DS_DIV};
    end else begin
      state_r <= state_nxt;
      ds_ctl_r <= ds_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_SQRT1: begin
        if (ds_done) begin
          rms_r <= ds_res[31:0];
          gated_r <= (ds_res[31:0] < {8'd0, gate_r});
          vol_r <= '0;
        end
      end
      ST_DIV2: begin
        if (ds_done) begin
          norm_r <= norm_q[15:0];
          if (norm_q == 48'd0) begin
            vol_r <= '0;
          end else if (norm_q[47:16] != 32'd0) begin
            vol_r <= rvm_pkg::VOL_FULL;
          end else begin
            vol_r <= {1'b0, norm_q[15:1]};
          end
        end
      end
      ST_SQRT2: begin
        if (ds_done) begin
          vol_r <= ds_res[15:0];
        end
      end
      ST_SQ: vol_r <= {1'b0, prod[31:17]};
      ST_LOGI: begin
        p_r <= lead;
        y_r <= y0;
        frac_r <= '0;
        k_r <= '0;
      end
      ST_LOG: begin
        y_r <= t_sq[31] ? t_sq[31:1] : t_sq[30:0];
        frac_r <= {frac_r[14:0], t_sq[31]};
        k_r <= k_r + 4'd1;
      end
      ST_EXPO: begin
        g_r <= 16'd0 - e_val[15:0];
        shift_r <= ((e_val[15:0] == 16'd0) ? 7'd15 : 7'd16) + ip_sat;
        zero_r <= ((((e_val[15:0] == 16'd0) ? 8'd15 : 8'd16) + {1'b0, ip_sat}) >= 8'd40);
        acc_r <= 32'h4000_0000;
        k_r <= '0;
      end
      ST_EXP: begin
        if (g_r[4'd15 - k_r]) begin
          acc_r <= t_sq;
        end
        k_r <= k_r + 4'd1;
      end
      ST_FIN: begin
        if (zero_r) begin
          vol_r <= '0;
        end else if (acc_sh > 32'd32768) begin
          vol_r <= rvm_pkg::VOL_FULL;
        end else begin
          vol_r <= acc_sh[15:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
      out_vol_r <= vol_r;
      out_gated_r <= gated_r;
      out_num_r <= num_r;
      out_trunc_r <= trunc_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.volume = out_vol_r;
  assign out_ch.gated = out_gated_r;
  assign out_ch.frame_number = out_num_r;
  assign out_ch.truncated = out_trunc_r;

  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_vol_r <= rvm_pkg::VOL_FULL)
    else $error("volume above full scale");

  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_gated_r |-> out_vol_r == 16'd0)
    else $error("gated frame with nonzero volume");

  a_trunc_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_trunc_r |-> out_num_r == 16'd0)
    else $error("truncated frame with nonzero frame number");

  a_busy_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    ds_ctl_r.start |-> state_r == ST_DIV1 || state_r == ST_SQRT1 || state_r == ST_DIV2
                       || state_r == ST_SQRT2)
    else $error("divider started outside a divide or root step");

endmodule

`default_nettype wire
